// ===== design/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RAMT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is low
`define RAMT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/ramt_pkg.sv =====
// shared types and constants of the range-add range-max tree
package ramt_pkg;

    localparam int unsigned DEF_MAX_ELEMENTS = 256;
    localparam int unsigned DEF_VALUE_WIDTH  = 32;

    localparam int unsigned CFG_WIDTH = 9;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_ADD   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    // write enables of the node memory pair
    typedef struct packed {
        logic max_we;
        logic down_we;
    } t_node_we;

endpackage

// ===== design/ramt_node_mem.sv =====
// node memory pair: subtree maximum and tag pending for the children
module ramt_node_mem import ramt_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                                   i_clk,
    input  t_node_we                               i_we,
    input  logic        [$clog2(4*MAX_ELEMENTS)-1:0] i_wr_addr,
    input  logic signed [VALUE_WIDTH-1:0]          i_wr_max,
    input  logic signed [VALUE_WIDTH-1:0]          i_wr_down,
    input  logic        [$clog2(4*MAX_ELEMENTS)-1:0] i_rd_addr,
    output logic signed [VALUE_WIDTH-1:0]          o_rd_max,
    output logic signed [VALUE_WIDTH-1:0]          o_rd_down
);

    localparam int unsigned NODES = 4 * MAX_ELEMENTS;

    logic signed [VALUE_WIDTH-1:0] mem_max  [NODES];
    logic signed [VALUE_WIDTH-1:0] mem_down [NODES];

    always_ff @(posedge i_clk) begin
        if (i_we.max_we) begin
            mem_max[i_wr_addr] <= i_wr_max;
        end
        o_rd_max <= mem_max[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.down_we) begin
            mem_down[i_wr_addr] <= i_wr_down;
        end
        o_rd_down <= mem_down[i_rd_addr];
    end

endmodule

// ===== design/ramt_leaf_mem.sv =====
// staging memory for leaf values before a build
module ramt_leaf_mem import ramt_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic        [$clog2(MAX_ELEMENTS)-1:0] i_wr_addr,
    input  logic signed [VALUE_WIDTH-1:0]        i_wr_data,
    input  logic        [$clog2(MAX_ELEMENTS)-1:0] i_rd_addr,
    output logic signed [VALUE_WIDTH-1:0]        o_rd_data
);

    logic signed [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

// ===== design/ramt_ctrl.sv =====
// tree walker: clearing sweeps, node read-modify-write and the call stack
module ramt_ctrl import ramt_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  t_op                                  i_op,
    input  logic        [7:0]                    i_first,
    input  logic        [7:0]                    i_last,
    input  logic signed [VALUE_WIDTH-1:0]        i_amount,
    input  logic        [$clog2(MAX_ELEMENTS)-1:0] i_last_node,
    input  logic                                 i_query_bad,
    output logic                                 o_idle,
    output logic                                 o_res_valid,
    input  logic                                 i_res_take,
    output logic signed [VALUE_WIDTH-1:0]        o_res_value,
    output logic                                 o_res_status
);

    localparam int unsigned VW    = VALUE_WIDTH;
    localparam int unsigned IW    = $clog2(MAX_ELEMENTS);
    localparam int unsigned NODES = 4 * MAX_ELEMENTS;
    localparam int unsigned NW    = $clog2(NODES);
    localparam int unsigned CW    = ((IW > 8) ? IW : 8) + 1;
    localparam int unsigned SD    = IW + 1;
    localparam int unsigned SW    = $clog2(SD + 1);
    localparam int unsigned SIW   = $clog2(SD);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SWEEP = 7'b0000100,
        S_READ  = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_RET   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    function automatic logic [IW-1:0] f_mid(input logic [IW-1:0] lo, input logic [IW-1:0] hi);
        logic [IW:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[IW:1];
    endfunction

    t_state                r_state, n_state;
    logic        [NW-1:0]  r_addr, n_addr;
    t_op                   r_op, n_op;
    logic        [CW-1:0]  r_f, n_f, r_l, n_l;
    logic signed [VW-1:0]  r_d, n_d;
    logic        [NW-1:0]  r_k, n_k;
    logic        [IW-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic signed [VW-1:0]  r_c, n_c;
    logic signed [VW-1:0]  r_ret, n_ret;
    logic        [SW-1:0]  r_sp, n_sp;
    logic signed [VW-1:0]  r_res, n_res;
    logic                  r_bad, n_bad;

    // call stack, one frame per partially covered node on the path, or per inner node in a build
    logic        [NW-1:0]  stk_k   [SD];
    logic        [IW-1:0]  stk_lo  [SD];
    logic        [IW-1:0]  stk_hi  [SD];
    logic signed [VW-1:0]  stk_c   [SD];
    logic signed [VW-1:0]  stk_acc [SD];
    logic                  stk_ph  [SD];
    logic                  w_push, w_upd;
    logic signed [VW-1:0]  w_push_c;
    logic        [SIW-1:0] w_top, w_free;

    t_node_we              w_we;
    logic        [NW-1:0]  w_wr_addr;
    logic signed [VW-1:0]  w_wr_max, w_wr_down;
    logic signed [VW-1:0]  rd_max, rd_down, leaf_rd;
    logic                  w_leaf_we;

    logic signed [VW-1:0]  w_m, w_md, w_dc, w_dcd, w_val;
    logic                  w_is_leaf, w_disj, w_cov;
    logic        [IW-1:0]  w_mid, w_top_mid;
    logic        [NW-1:0]  w_c1, w_top_c2;

    ramt_node_mem #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_WIDTH(VALUE_WIDTH)) u_node (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_max  (w_wr_max),
        .i_wr_down (w_wr_down),
        .i_rd_addr (r_k),
        .o_rd_max  (rd_max),
        .o_rd_down (rd_down)
    );

    ramt_leaf_mem #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_WIDTH(VALUE_WIDTH)) u_leaf (
        .i_clk     (i_clk),
        .i_we      (w_leaf_we),
        .i_wr_addr (IW'(i_first)),
        .i_wr_data (i_amount),
        .i_rd_addr (r_lo),
        .o_rd_data (leaf_rd)
    );

    assign w_top     = SIW'(r_sp - 1'b1);
    assign w_free    = SIW'(r_sp);
    assign w_m       = rd_max + r_c;
    assign w_md      = w_m + r_d;
    assign w_dc      = rd_down + r_c;
    assign w_dcd     = w_dc + r_d;
    assign w_is_leaf = (r_lo == r_hi);
    assign w_disj    = (CW'(r_lo) > r_l) || (CW'(r_hi) < r_f);
    assign w_cov     = (CW'(r_lo) >= r_f) && (CW'(r_hi) <= r_l);
    assign w_mid     = f_mid(r_lo, r_hi);
    assign w_c1      = (r_k << 1) | NW'(1);
    assign w_top_mid = f_mid(stk_lo[w_top], stk_hi[w_top]);
    assign w_top_c2  = (stk_k[w_top] << 1) + NW'(2);
    assign w_val     = (stk_acc[w_top] >= r_ret) ? stk_acc[w_top] : r_ret;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_op      = r_op;
        n_f       = r_f;
        n_l       = r_l;
        n_d       = r_d;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_c       = r_c;
        n_ret     = r_ret;
        n_sp      = r_sp;
        n_res     = r_res;
        n_bad     = r_bad;
        w_we      = '0;
        w_wr_addr = r_k;
        w_wr_max  = '0;
        w_wr_down = '0;
        w_leaf_we = 1'b0;
        w_push    = 1'b0;
        w_push_c  = '0;
        w_upd     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we      = '{max_we: 1'b1, down_we: 1'b1};
                w_wr_addr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == NW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_f   = CW'(i_first);
                    n_l   = CW'(i_last);
                    n_d   = i_amount;
                    n_k   = '0;
                    n_lo  = '0;
                    n_hi  = i_last_node;
                    n_c   = '0;
                    n_sp  = '0;
                    n_res = '0;
                    n_bad = 1'b0;
                    n_addr = '0;
                    case (i_op)
                        OP_LOAD: begin
                            w_leaf_we = (CW'(i_first) < CW'(MAX_ELEMENTS));
                            n_state   = S_DONE;
                        end
                        OP_BUILD: begin
                            n_state = S_SWEEP;
                        end
                        OP_ADD: begin
                            n_state = S_READ;
                        end
                        OP_QUERY: begin
                            n_bad   = i_query_bad;
                            n_state = i_query_bad ? S_DONE : S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // build drops every pending tag first
                w_we      = '{max_we: 1'b0, down_we: 1'b1};
                w_wr_addr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == NW'(NODES - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_BUILD) begin
                    if (w_is_leaf) begin
                        w_we.max_we = 1'b1;
                        w_wr_max    = leaf_rd;
                        n_ret       = leaf_rd;
                        n_state     = S_RET;
                    end else begin
                        w_push = 1'b1;
                    end
                end else if (w_disj) begin
                    w_we      = '{max_we: 1'b1, down_we: !w_is_leaf};
                    w_wr_max  = w_m;
                    w_wr_down = w_dc;
                    n_ret     = (r_op == OP_ADD) ? w_m : {1'b1, {(VW-1){1'b0}}};
                    n_state   = S_RET;
                end else if (w_cov) begin
                    w_we = '{max_we: 1'b1, down_we: !w_is_leaf};
                    if (r_op == OP_ADD) begin
                        w_wr_max  = w_md;
                        w_wr_down = w_dcd;
                        n_ret     = w_md;
                    end else begin
                        w_wr_max  = w_m;
                        w_wr_down = w_dc;
                        n_ret     = w_m;
                    end
                    n_state = S_RET;
                end else begin
                    // partial overlap: tag moves to both children
                    w_we      = '{max_we: 1'b1, down_we: 1'b1};
                    w_wr_max  = w_m;
                    w_wr_down = '0;
                    w_push    = 1'b1;
                    w_push_c  = w_dc;
                end
                if (w_push) begin
                    n_sp    = r_sp + 1'b1;
                    n_k     = w_c1;
                    n_hi    = w_mid;
                    n_c     = w_push_c;
                    n_state = S_READ;
                end
            end
            S_RET: begin
                if (r_sp == '0) begin
                    n_res   = (r_op == OP_QUERY) ? r_ret : '0;
                    n_state = S_DONE;
                end else if (!stk_ph[w_top]) begin
                    w_upd   = 1'b1;
                    n_k     = w_top_c2;
                    n_lo    = w_top_mid + 1'b1;
                    n_hi    = stk_hi[w_top];
                    n_c     = stk_c[w_top];
                    n_state = S_READ;
                end else begin
                    w_we.max_we = (r_op != OP_QUERY);
                    w_wr_addr   = stk_k[w_top];
                    w_wr_max    = w_val;
                    n_ret       = w_val;
                    n_sp        = r_sp - 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_sp    <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_f   <= n_f;
        r_l   <= n_l;
        r_d   <= n_d;
        r_k   <= n_k;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_c   <= n_c;
        r_ret <= n_ret;
        r_res <= n_res;
        r_bad <= n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            stk_k[w_free]  <= r_k;
            stk_lo[w_free] <= r_lo;
            stk_hi[w_free] <= r_hi;
            stk_c[w_free]  <= w_push_c;
            stk_ph[w_free] <= 1'b0;
        end else if (w_upd) begin
            stk_ph[w_top]  <= 1'b1;
            stk_acc[w_top] <= r_ret;
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_value  = r_res;
    assign o_res_status = r_bad;

endmodule

// ===== design/range_add_range_max_tree_unit.sv =====
// top level of the lazy-tag range-add range-max tree
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------------
//  in        | i_valid / o_ready   | i_operation i_first_index i_last_index i_amount
//  out       | o_valid / i_ready   | o_max_value o_status
//  config    | i_cfg_wr_en         | i_cfg_wr_data (element count)
//
// after reset a clearing pass writes all 4*MAX_ELEMENTS nodes, one per cycle,
// and o_ready stays low for those cycles
// load writes the leaf memory on acceptance; build first sweeps the pending
// tag of every node, then walks the tree; add and query read each visited
// node, then modify-write it, with return steps that combine the children,
// about 4 nodes per tree level; a waiting result sits in the output register;
// the walker stops only while it is done and that register is full and stalled
module range_add_range_max_tree_unit import ramt_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int unsigned VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_operation,
    input  logic [7:0]           i_first_index,
    input  logic [7:0]           i_last_index,
    input  logic signed [31:0]   i_amount,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_max_value,
    output logic                 o_status,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] i_cfg_wr_data
);

    localparam int unsigned IW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = ((IW > 8) ? IW : 8) + 1;

    logic [CFG_WIDTH-1:0]          r_count;
    logic [CW-1:0]                 w_active;
    logic [IW-1:0]                 w_last_node;
    logic                          w_query_bad;
    logic                          w_accept;
    logic                          w_slot_free;
    logic                          w_res_valid;
    logic                          w_res_status;
    logic signed [VALUE_WIDTH-1:0] w_res_value;
    logic                          r_out_valid;
    logic signed [31:0]            r_max_value;
    logic                          r_status;

    // element count register; write it only while the unit is idle, the block does not check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    // zero counts act as one, oversized counts as the capacity
    always_comb begin
        if (r_count == '0) begin
            w_active = CW'(1);
        end else if (CW'(r_count) > CW'(MAX_ELEMENTS)) begin
            w_active = CW'(MAX_ELEMENTS);
        end else begin
            w_active = CW'(r_count);
        end
    end

    assign w_last_node = IW'(w_active - 1'b1);
    assign w_query_bad = (i_first_index > i_last_index) || (CW'(i_last_index) >= w_active);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;

    ramt_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept),
        .i_op         (t_op'(i_operation)),
        .i_first      (i_first_index),
        .i_last       (i_last_index),
        .i_amount     (VALUE_WIDTH'(i_amount)),
        .i_last_node  (w_last_node),
        .i_query_bad  (w_query_bad),
        .o_idle       (o_ready),
        .o_res_valid  (w_res_valid),
        .i_res_take   (w_slot_free),
        .o_res_value  (w_res_value),
        .o_res_status (w_res_status)
    );

    // output register, one transaction deep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_slot_free) begin
            r_max_value <= 32'(w_res_value);
            r_status    <= w_res_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_max_value = r_max_value;
    assign o_status    = r_status;

endmodule

// ===== design/ramt_checker.sv =====
// port-level checks of the tree unit and their binding
`include "assert_macros.svh"

module ramt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_max_value,
    input logic               o_status
);

    // a stalled result holds
    `RAMT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_max_value) && $stable(o_status))

    // an invalid query range reports a zero maximum
    `RAMT_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_valid && o_status, o_max_value == 32'sd0)

    // the unit works on one transaction at a time
    `RAMT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind range_add_range_max_tree_unit ramt_checker u_ramt_checker (.*);

// ===== bench/range_add_range_max_tree_checker.sv =====
// result checker with a lazy-tag max tree predictor for the range tree unit
`timescale 1ns / 100ps

module range_add_range_max_tree_checker import ramt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_ready_in,
    input  logic [1:0]           i_operation,
    input  logic [7:0]           i_first_index,
    input  logic [7:0]           i_last_index,
    input  logic [31:0]          i_amount,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [31:0]          i_max_value,
    input  logic                 i_status,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] i_cfg_wr_data,
    output int                   o_fail_count,
    output int                   o_outstanding
);
    localparam int NODES  = 1024;
    localparam int LEAVES = 256;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;

    typedef struct {
        logic [31:0] max_value;
        logic        status;
    } t_answer;

    logic [31:0]          tree_max [NODES];
    logic [31:0]          tree_tag [NODES];
    logic [31:0]          leaf_val [LEAVES];
    logic [CFG_WIDTH-1:0] count_reg;
    t_answer              answers [$];

    assign o_outstanding = answers.size();

    function automatic logic [31:0] larger(logic [31:0] a, logic [31:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

    function automatic int live_count();
        if (count_reg == 0) return 1;
        if (count_reg > LEAVES) return LEAVES;
        return int'(count_reg);
    endfunction

    function automatic void add_tag(int k, logic [31:0] d);
        if (k < NODES) tree_tag[k] = tree_tag[k] + d;
    endfunction

    function automatic void push_tag(int k, int lo, int hi);
        logic [31:0] p;
        if (k >= NODES) return;
        p = tree_tag[k];
        if (p != 0) begin
            tree_max[k] = tree_max[k] + p;
            if (lo != hi) begin
                add_tag(2*k+1, p);
                add_tag(2*k+2, p);
            end
            tree_tag[k] = 0;
        end
    endfunction

    function automatic logic [31:0] node_val(int k);
        return (k < NODES) ? tree_max[k] : 32'h0;
    endfunction

    function automatic void build_tree(int k, int lo, int hi);
        int mid;
        if (k >= NODES || lo > hi) return;
        if (lo == hi) begin
            tree_max[k] = leaf_val[lo];
            return;
        end
        mid = (lo + hi) / 2;
        build_tree(2*k+1, lo, mid);
        build_tree(2*k+2, mid+1, hi);
        tree_max[k] = larger(node_val(2*k+1), node_val(2*k+2));
    endfunction

    function automatic void add_range(int k, int lo, int hi, int f, int l, logic [31:0] d);
        int mid;
        if (k >= NODES) return;
        push_tag(k, lo, hi);
        if (lo > hi || lo > l || hi < f) return;
        if (lo >= f && hi <= l) begin
            tree_max[k] = tree_max[k] + d;
            if (lo != hi) begin
                add_tag(2*k+1, d);
                add_tag(2*k+2, d);
            end
            return;
        end
        mid = (lo + hi) / 2;
        add_range(2*k+1, lo, mid, f, l, d);
        add_range(2*k+2, mid+1, hi, f, l, d);
        tree_max[k] = larger(node_val(2*k+1), node_val(2*k+2));
    endfunction

    function automatic logic [31:0] range_max(int k, int lo, int hi, int f, int l);
        int mid;
        if (k >= NODES) return MOST_NEG;
        push_tag(k, lo, hi);
        // disjoint subtrees never win
        if (lo > hi || lo > l || hi < f) return MOST_NEG;
        if (lo >= f && hi <= l) return tree_max[k];
        mid = (lo + hi) / 2;
        return larger(range_max(2*k+1, lo, mid, f, l), range_max(2*k+2, mid+1, hi, f, l));
    endfunction

    function automatic t_answer apply_item(t_op op, int f, int l, logic [31:0] amt);
        t_answer a;
        int      n;
        a.max_value = 0;
        a.status    = 0;
        n = live_count();
        case (op)
            OP_LOAD: begin
                leaf_val[f] = amt;
            end
            OP_BUILD: begin
                foreach (tree_tag[i]) tree_tag[i] = 0;
                build_tree(0, 0, n-1);
            end
            OP_ADD: begin
                add_range(0, 0, n-1, f, l, amt);
            end
            default: begin
                if (f > l || l >= n) a.status = 1;
                else a.max_value = range_max(0, 0, n-1, f, l);
            end
        endcase
        return a;
    endfunction

    initial begin
        foreach (tree_max[i]) begin
            tree_max[i] = 0;
            tree_tag[i] = 0;
        end
        foreach (leaf_val[i]) leaf_val[i] = 0;
        count_reg = CFG_RESET;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_cfg_wr_en) count_reg <= i_cfg_wr_data;
            if (i_valid && i_ready_in)
                answers.push_back(apply_item(t_op'(i_operation), int'(i_first_index),
                                             int'(i_last_index), i_amount));
            if (i_out_valid && i_out_ready) begin
                if (answers.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result: max %0d status %0d",
                                 $signed(i_max_value), i_status);
                end else begin
                    want = answers.pop_front();
                    if (want.max_value !== i_max_value || want.status !== i_status) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected max %0d status %0d, got max %0d status %0d",
                                     $signed(want.max_value), want.status,
                                     $signed(i_max_value), i_status);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/range_add_range_max_tree_unit_test.sv =====
// stimulus and verdict for the range-add range-max tree unit
`timescale 1ns / 100ps

module range_add_range_max_tree_unit_test;
    import ramt_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_operation;
    logic [7:0]           i_first_index;
    logic [7:0]           i_last_index;
    logic signed [31:0]   i_amount;
    logic                 o_valid;
    logic                 i_ready;
    logic signed [31:0]   o_max_value;
    logic                 o_status;
    logic                 i_cfg_wr_en;
    logic [CFG_WIDTH-1:0] i_cfg_wr_data;

    int fail_count;
    int outstanding;

    // stimulus side knobs seen by the receiver process
    bit calm;          // no idling on either side
    bit long_hold;     // ask the receiver for one long hold-off
    int live_n;        // element count in effect for range picks
    bit loaded [256];  // leaves written since reset

    range_add_range_max_tree_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_max_value   (o_max_value),
        .o_status      (o_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    range_add_range_max_tree_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_operation   (i_operation),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .i_amount      (i_amount),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_max_value   (o_max_value),
        .i_status      (o_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: covers the clearing pass, wide builds and every stall
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 3_000_000) begin
                $display("FAIL range_add_range_max_tree_unit");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int span;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                // hold off long enough for the block to back up its input
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end else if (calm) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                span = $urandom_range(1, 16);
                i_ready <= ($urandom_range(0, 2) != 0);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // offer one transaction, with an optional idle burst first
    task automatic send_item(t_op op, logic [7:0] f, logic [7:0] l, logic [31:0] amt);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_first_index <= f;
        i_last_index  <= l;
        i_amount      <= amt;
        if (op == OP_LOAD) loaded[f] = 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // let every result come back, then settle before touching the register
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFG_WIDTH-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        if (value == 0) live_n = 1;
        else if (value > 256) live_n = 256;
        else live_n = int'(value);
    endtask

    function automatic bit leaves_ready();
        for (int i = 0; i < live_n; i++)
            if (!loaded[i]) return 0;
        return 1;
    endfunction

    function automatic int first_unloaded();
        for (int i = 0; i < 256; i++)
            if (!loaded[i]) return i;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] pick_amount();
        if ($urandom_range(0, 1) == 0) return 32'($urandom_range(0, 200)) - 32'd100;
        return $urandom;
    endfunction

    // one random transaction; builds only once every live leaf has been loaded
    task automatic random_item();
        int          roll;
        int          f;
        int          l;
        logic [31:0] amt;
        roll = $urandom_range(0, 99);
        amt  = pick_amount();
        if ($urandom_range(0, 6) == 0) begin
            // off-range or reversed bounds
            f = $urandom_range(0, 255);
            l = $urandom_range(0, 255);
        end else begin
            f = $urandom_range(0, live_n - 1);
            l = $urandom_range(f, live_n - 1);
        end
        if (roll < 8 && leaves_ready())
            send_item(OP_BUILD, 8'(f), 8'(l), amt);
        else if (roll < 33) begin
            if ($urandom_range(0, 1) == 0) f = first_unloaded();
            else f = $urandom_range(0, 255);
            send_item(OP_LOAD, 8'(f), 8'(l), amt);
        end else if (roll < 65)
            send_item(OP_ADD, 8'(f), 8'(l), amt);
        else
            send_item(OP_QUERY, 8'(f), 8'(l), amt);
    endtask

    initial begin
        logic [CFG_WIDTH-1:0] counts [7];
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_operation   <= OP_LOAD;
        i_first_index <= '0;
        i_last_index  <= '0;
        i_amount      <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        calm      = 0;
        long_hold = 0;
        live_n    = 256;
        foreach (loaded[i]) loaded[i] = 0;
        counts = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd13, 9'd100, 9'd2};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a four-element tree with value extremes and wrapping sums
        write_count(9'd4);
        send_item(OP_QUERY, 8'd0, 8'd3, 32'h0);        // zeroed tree before any build
        send_item(OP_LOAD, 8'd0, 8'hff, 32'h7fff_ffff);
        send_item(OP_LOAD, 8'd1, 8'h00, 32'h8000_0000);
        send_item(OP_LOAD, 8'd2, 8'h55, 32'h0);
        send_item(OP_LOAD, 8'd3, 8'haa, 32'hffff_ffff);
        send_item(OP_BUILD, 8'd0, 8'd0, 32'h0);
        send_item(OP_QUERY, 8'd0, 8'd3, 32'h0);
        send_item(OP_QUERY, 8'd1, 8'd1, 32'h0);
        send_item(OP_QUERY, 8'd1, 8'd3, 32'h0);
        send_item(OP_QUERY, 8'd3, 8'd0, 32'h0);        // reversed bounds
        send_item(OP_QUERY, 8'd0, 8'd4, 32'h0);        // end past the count
        send_item(OP_QUERY, 8'hff, 8'hff, 32'hffff_ffff);
        send_item(OP_ADD, 8'd0, 8'd0, 32'd1);          // top value wraps negative
        send_item(OP_ADD, 8'd3, 8'd0, 32'd5);          // reversed add does nothing
        send_item(OP_ADD, 8'd2, 8'hff, 32'h8000_0000); // partly outside
        send_item(OP_ADD, 8'd1, 8'd2, 32'h7fff_ffff);
        send_item(OP_QUERY, 8'd0, 8'd3, 32'h0);
        send_item(OP_QUERY, 8'd2, 8'd2, 32'h0);
        send_item(OP_LOAD, 8'hff, 8'hff, 32'h1234_5678);
        send_item(OP_ADD, 8'd0, 8'd3, 32'hffff_fffe);
        send_item(OP_QUERY, 8'd0, 8'd1, 32'h0);
        send_item(OP_BUILD, 8'hff, 8'hff, 32'hffff_ffff); // clears pending tags
        send_item(OP_QUERY, 8'd0, 8'd3, 32'h0);
        drain();

        // random phases across counts, extremes included, no forced rebuild
        for (int p = 0; p < 7; p++) begin
            write_count(counts[p]);
            if (p == 2) long_hold = 1;
            if (p == 6) calm = 1;
            repeat (62) random_item();
            drain();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("PASS range_add_range_max_tree_unit");
        else
            $display("FAIL range_add_range_max_tree_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ramt_pkg.sv
design/ramt_node_mem.sv
design/ramt_leaf_mem.sv
design/ramt_ctrl.sv
design/range_add_range_max_tree_unit.sv
design/ramt_checker.sv
bench/range_add_range_max_tree_checker.sv
bench/range_add_range_max_tree_unit_test.sv
